[rtl/core/lidar_scan_packet_decoder_defines.svh]
// Assertion macros shared by the lidar scan decoder RTL.
`ifndef LIDAR_SCAN_PACKET_DECODER_DEFINES_SVH
`define LIDAR_SCAN_PACKET_DECODER_DEFINES_SVH

// Checked on every rising edge of clk, muted while rst is high.
`define LSPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define LSPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/lspd_pkg.sv]
// Types, codes and constants of the lidar scan decoder.
package lspd_pkg;

  localparam int HEADER_BYTES_DEF = 7;
  localparam int REC_BYTES        = 5;
  localparam int REC_CNT_W        = 3;
  localparam int REC_IDX_W        = 2;

  localparam logic [7:0]  CMD_FLAG   = 8'hA5;
  localparam logic [7:0]  CMD_SCAN   = 8'h20;
  localparam logic [7:0]  CMD_STOP   = 8'h25;
  localparam logic [15:0] ANGLE_FULL = 16'd23040;

  localparam logic [5:0]  MIN_QUALITY_RST  = 6'd10;
  localparam logic [15:0] MIN_DISTANCE_RST = 16'd40;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 1'd1;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic {
    KIND_MEAS = 1'b0,
    KIND_TX   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        tx_byte;
    logic [5:0]        quality;
    logic signed [15:0] angle;
    logic [15:0]       distance;
    logic              motor_on;
    logic              last;
  } res_t;

endpackage

[rtl/core/lspd_rec_decode.sv]
// Measurement record decode and threshold filter.
module lspd_rec_decode (
  input  logic [7:0]       rec_bytes [lspd_pkg::REC_BYTES-1],
  input  logic [7:0]       final_byte,
  input  logic [5:0]       min_quality,
  input  logic [15:0]      min_distance,
  output lspd_pkg::res_t   meas,
  output logic             keep
);
  import lspd_pkg::*;

  logic [14:0] raw_angle;
  logic [15:0] dist_val;
  logic [5:0]  qual;

  always_comb begin
    qual      = rec_bytes[0][7:2];
    raw_angle = {rec_bytes[2], rec_bytes[1][7:1]};
    dist_val  = {final_byte, rec_bytes[3]};
    keep      = (qual >= min_quality) && (dist_val >= min_distance);

    meas          = '0;
    meas.kind     = KIND_MEAS;
    meas.tx_byte  = 8'd0;
    meas.quality  = qual;
    meas.angle    = $signed(ANGLE_FULL - {1'b0, raw_angle});
    meas.distance = dist_val;
    meas.motor_on = 1'b1;
    meas.last     = 1'b1;
  end

endmodule

[rtl/core/lidar_scan_packet_decoder.sv]
// Top level of the lidar scan link decoder.
//
// Slave stream: s_tuser carries the function (received byte, start, stop),
// s_tdata the received byte. Master stream: one result per transfer, either
// a command byte to send to the sensor (m_tuser = 1) or a decoded
// measurement (m_tuser = 0); m_tlast marks the final result of an input.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 minimum quality, 1 minimum distance) on the clock edge.
// A result sits in the output register in the cycle after the input
// transfer. Received bytes go at one per cycle while the receiver takes
// each result; a start while stopped or a stop while scanning gives two
// command bytes and holds the input off until the second byte moves from
// the hold register into the output register. The hold register behind
// the output register is one deep.
// Reset: stopped, motor off, counters clear, thresholds 10 and 40.
// A stalled receiver keeps the output and hold registers full; input ready
// drops once the hold register is occupied, and a byte that yields at most
// one result is still taken in the cycle the output is drained.
`include "lidar_scan_packet_decoder_defines.svh"

module lidar_scan_packet_decoder #(
  parameter int HEADER_BYTES = lspd_pkg::HEADER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // rx_byte[7:0]
  input  logic [1:0]                         s_tuser,  // func[1:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tx_byte[7:0], quality[13:8], angle[29:14], distance[45:30],
  // motor_on[46], zero[47]
  output logic [47:0]                        m_tdata,
  output logic                               m_tuser,  // kind[0]
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [lspd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lspd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lspd_pkg::*;

  localparam int HDR_W = (HEADER_BYTES < 1) ? 1 : $clog2(HEADER_BYTES + 1);
  localparam logic [HDR_W-1:0] HDR_LAST = HDR_W'(HEADER_BYTES);

  logic [5:0]           min_quality;
  logic [15:0]          min_distance;
  logic                 scanning, scanning_next;
  logic [HDR_W-1:0]     header_count, header_count_next;
  logic [REC_CNT_W-1:0] record_count, record_count_next;
  logic [7:0]           record_bytes [REC_BYTES-1];

  res_t out_res, pend_res;
  logic out_valid, pend_valid;

  res_t res0, res1;
  logic [1:0] n_res;
  logic rec_wr;
  res_t meas;
  logic keep;
  logic s_fire, m_fire;

  assign s_tready = !pend_valid && (!out_valid || m_tready);
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;

  lspd_rec_decode u_rec_decode (
    .rec_bytes    (record_bytes),
    .final_byte   (s_tdata),
    .min_quality  (min_quality),
    .min_distance (min_distance),
    .meas         (meas),
    .keep         (keep)
  );

  always_comb begin
    scanning_next     = scanning;
    header_count_next = header_count;
    record_count_next = record_count;
    rec_wr            = 1'b0;
    n_res             = 2'd0;
    res0              = '0;
    res1              = '0;
    res0.kind         = KIND_TX;
    res0.tx_byte      = CMD_FLAG;
    res1.kind         = KIND_TX;
    res1.last         = 1'b1;
    case (s_tuser)
      FUNC_START: begin
        if (!scanning) begin
          scanning_next     = 1'b1;
          header_count_next = '0;
          record_count_next = '0;
          n_res             = 2'd2;
          res0.motor_on     = 1'b1;
          res1.motor_on     = 1'b1;
          res1.tx_byte      = CMD_SCAN;
        end
      end
      FUNC_STOP: begin
        if (scanning) begin
          scanning_next = 1'b0;
          n_res         = 2'd2;
          res1.tx_byte  = CMD_STOP;
        end
      end
      FUNC_BYTE: begin
        if (scanning) begin
          if (header_count < HDR_LAST) begin
            header_count_next = header_count + 1'b1;
          end else if (record_count < REC_CNT_W'(REC_BYTES - 1)) begin
            rec_wr            = 1'b1;
            record_count_next = record_count + 1'b1;
          end else begin
            record_count_next = '0;
            if (keep) begin
              n_res = 2'd1;
              res0  = meas;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_quality  <= MIN_QUALITY_RST;
      min_distance <= MIN_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_QUALITY:  min_quality  <= cfg_data[5:0];
        CFG_MIN_DISTANCE: min_distance <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning     <= 1'b0;
      header_count <= '0;
      record_count <= '0;
    end else if (s_fire) begin
      scanning     <= scanning_next;
      header_count <= header_count_next;
      record_count <= record_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && rec_wr) begin
      record_bytes[record_count[REC_IDX_W-1:0]] <= s_tdata;
    end
  end

  // Output register plus one hold slot for the second command byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid) begin
        if (m_fire) begin
          out_res    <= pend_res;
          pend_valid <= 1'b0;
        end
      end else if (s_fire && n_res != 2'd0) begin
        out_valid <= 1'b1;
        out_res   <= res0;
        if (n_res == 2'd2) begin
          pend_valid <= 1'b1;
          pend_res   <= res1;
        end
      end else if (m_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.motor_on, out_res.distance, out_res.angle,
                     out_res.quality, out_res.tx_byte};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

  `LSPD_ASSERT_ALWAYS(a_pend_needs_out, pend_valid |-> out_valid, "hold slot full, output empty")
  `LSPD_ASSERT(a_pend_blocks_in, pend_valid |-> !s_tready, "input taken while hold slot full")
  `LSPD_ASSERT(a_pend_is_cmd, pend_valid |-> (pend_res.kind == KIND_TX && pend_res.last), "hold slot not a final command byte")
  `LSPD_ASSERT(a_meas_form, (out_valid && out_res.kind == KIND_MEAS) |-> (out_res.last && out_res.motor_on), "measurement without last or motor")
  `LSPD_ASSERT(a_start_scans, (s_fire && s_tuser == FUNC_START) |=> scanning, "start did not enter scanning")

endmodule
